### hdl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Types and constants shared by the tinted gamma ramp entry core.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int IDX_W   = 10;
    localparam int TINT_W  = 8;
    localparam int SIZE_W  = 11;
    localparam int LAST_W  = 11;
    localparam int LEVEL_W = 16;
    localparam int PROD_W  = IDX_W + TINT_W;
    localparam int NUM_W   = PROD_W + LEVEL_W;
    localparam int DEN_W   = LAST_W + TINT_W;
    localparam int NCH     = 3;
    localparam int CIDX_W  = 2;
    localparam int DATA_W  = SIZE_W;
    localparam int LATENCY = 2 + LEVEL_W;

    localparam logic [TINT_W-1:0] TINT_RESET = 8'hff;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd256;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TINT_RED   = 2'd0,
        CFG_TINT_GREEN = 2'd1,
        CFG_TINT_BLUE  = 2'd2,
        CFG_RAMP_SIZE  = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [NCH-1:0][TINT_W-1:0] tint;
        logic [LAST_W-1:0]          last;
        logic [DEN_W-1:0]           den;
    } t_cfg;

    typedef struct packed {
        logic                        valid;
        logic                        clamped;
        logic [NCH-1:0][NUM_W-1:0]   rem;
        logic [NCH-1:0][LEVEL_W-1:0] quo;
    } t_div_word;

endpackage

### hdl/tgr_cfg_regs.sv
// ----------------------------------------------------------------------------
// tgr_cfg_regs
// Configuration registers, effective last ramp entry and the divisor.
// ----------------------------------------------------------------------------
module tgr_cfg_regs #(
    parameter int MAX_RAMP_SIZE = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [tgr_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [tgr_pkg::DATA_W-1:0]  i_cfg_data,
    output tgr_pkg::t_cfg               o_cfg
);

    localparam int SZ_W = 13;
    localparam logic [SZ_W-1:0] MAX_SIZE = SZ_W'(MAX_RAMP_SIZE);

    logic [tgr_pkg::NCH-1:0][tgr_pkg::TINT_W-1:0] r_tint;
    logic [tgr_pkg::SIZE_W-1:0]                   r_size;
    logic [tgr_pkg::DEN_W-1:0]                    r_den;
    logic [SZ_W-1:0]                              size_eff;
    logic [tgr_pkg::LAST_W-1:0]                   last;
    logic [tgr_pkg::DEN_W-1:0]                    last_nz;
    logic [tgr_pkg::DEN_W-1:0]                    n_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tint <= {tgr_pkg::NCH{tgr_pkg::TINT_RESET}};
            r_size <= tgr_pkg::SIZE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tgr_pkg::CFG_TINT_RED:   r_tint[0] <= i_cfg_data[tgr_pkg::TINT_W-1:0];
                tgr_pkg::CFG_TINT_GREEN: r_tint[1] <= i_cfg_data[tgr_pkg::TINT_W-1:0];
                tgr_pkg::CFG_TINT_BLUE:  r_tint[2] <= i_cfg_data[tgr_pkg::TINT_W-1:0];
                tgr_pkg::CFG_RAMP_SIZE:  r_size    <= i_cfg_data[tgr_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        size_eff = (r_size == '0) ? SZ_W'(1) : SZ_W'(r_size);
        if (size_eff > MAX_SIZE) begin
            size_eff = MAX_SIZE;
        end
        last    = tgr_pkg::LAST_W'(size_eff - SZ_W'(1));
        last_nz = (last == '0) ? tgr_pkg::DEN_W'(1) : tgr_pkg::DEN_W'(last);
        n_den   = (last_nz << tgr_pkg::TINT_W) - last_nz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_den <= tgr_pkg::DEN_W'(255 * 255);
        end else begin
            r_den <= n_den;
        end
    end

    assign o_cfg.tint = r_tint;
    assign o_cfg.last = last;
    assign o_cfg.den  = r_den;

endmodule

### hdl/tgr_front.sv
// ----------------------------------------------------------------------------
// tgr_front
// Index clamp, tint products and dividend formation in two stages.
// ----------------------------------------------------------------------------
module tgr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [tgr_pkg::IDX_W-1:0]  i_ramp_index,
    input  tgr_pkg::t_cfg              i_cfg,
    output tgr_pkg::t_div_word         o_word
);

    logic                                          clamped;
    logic [tgr_pkg::IDX_W-1:0]                     idx;
    logic                                          r_a_valid;
    logic                                          r_a_clamped;
    logic [tgr_pkg::NCH-1:0][tgr_pkg::PROD_W-1:0]  r_a_prod;
    tgr_pkg::t_div_word                            r_b;
    tgr_pkg::t_div_word                            n_b;

    always_comb begin
        clamped = tgr_pkg::LAST_W'(i_ramp_index) > i_cfg.last;
        idx     = clamped ? tgr_pkg::IDX_W'(i_cfg.last) : i_ramp_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b.valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b.valid <= n_b.valid;
        end
        r_a_clamped <= clamped;
        for (int c = 0; c < tgr_pkg::NCH; c++) begin
            r_a_prod[c] <= tgr_pkg::PROD_W'(idx) * tgr_pkg::PROD_W'(i_cfg.tint[c]);
        end
        r_b.clamped <= n_b.clamped;
        r_b.rem     <= n_b.rem;
        r_b.quo     <= n_b.quo;
    end

    always_comb begin
        n_b.valid   = r_a_valid;
        n_b.clamped = r_a_clamped;
        for (int c = 0; c < tgr_pkg::NCH; c++) begin
            n_b.rem[c] = (tgr_pkg::NUM_W'(r_a_prod[c]) << tgr_pkg::LEVEL_W)
                       - tgr_pkg::NUM_W'(r_a_prod[c]);
            n_b.quo[c] = '0;
        end
    end

    assign o_word = r_b;

endmodule

### hdl/tgr_div_stage.sv
// ----------------------------------------------------------------------------
// tgr_div_stage
// One restoring division step that settles one quotient bit per channel.
// ----------------------------------------------------------------------------
module tgr_div_stage #(
    parameter int BIT = 0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tgr_pkg::t_div_word         i_word,
    input  logic [tgr_pkg::DEN_W-1:0]  i_den,
    output tgr_pkg::t_div_word         o_word
);

    logic [tgr_pkg::NUM_W-1:0] den_sh;
    tgr_pkg::t_div_word        n_word;
    tgr_pkg::t_div_word        r_word;

    always_comb begin
        den_sh = tgr_pkg::NUM_W'(i_den) << BIT;
        n_word = i_word;
        for (int c = 0; c < tgr_pkg::NCH; c++) begin
            if (i_word.rem[c] >= den_sh) begin
                n_word.rem[c]      = i_word.rem[c] - den_sh;
                n_word.quo[c][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
        r_word.clamped <= n_word.clamped;
        r_word.rem     <= n_word.rem;
        r_word.quo     <= n_word.quo;
    end

    assign o_word = r_word;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word.valid |-> (r_word.rem[0] < (tgr_pkg::NUM_W'(i_den) << BIT))
                      && (r_word.rem[1] < (tgr_pkg::NUM_W'(i_den) << BIT))
                      && (r_word.rem[2] < (tgr_pkg::NUM_W'(i_den) << BIT)))
        else $error("division remainder out of range");
`endif

endmodule

### hdl/tinted_gamma_ramp_entry_core.sv
// ----------------------------------------------------------------------------
// tinted_gamma_ramp_entry_core
// Tinted linear gamma ramp: three 16-bit levels for one ramp index.
// ----------------------------------------------------------------------------
// The core takes one ramp index in every clock cycle and never raises busy.
// Each word comes out on the result ports after the front stages and the
// divider, marked by o_result_valid for one cycle, in the order the indexes
// went in. The divider is a 16-stage pipeline that settles one quotient bit
// per stage for all three channels at once, behind one stage for the clamp
// and tint products and one for the dividend. Configuration writes are taken
// in any cycle but must only be made while no result is still on its way.
module tinted_gamma_ramp_entry_core #(
    parameter int MAX_RAMP_SIZE = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tgr_pkg::IDX_W-1:0]   i_ramp_index,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tgr_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [tgr_pkg::DATA_W-1:0]  i_cfg_data,
    output logic                        o_result_valid,
    output logic [tgr_pkg::LEVEL_W-1:0] o_red_level,
    output logic [tgr_pkg::LEVEL_W-1:0] o_green_level,
    output logic [tgr_pkg::LEVEL_W-1:0] o_blue_level,
    output logic                        o_index_clamped
);

    tgr_pkg::t_cfg                             cfg;
    tgr_pkg::t_div_word [tgr_pkg::LEVEL_W:0]   word;
    logic                                      accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    tgr_cfg_regs #(
        .MAX_RAMP_SIZE (MAX_RAMP_SIZE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tgr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_ramp_index (i_ramp_index),
        .i_cfg        (cfg),
        .o_word       (word[tgr_pkg::LEVEL_W])
    );

    for (genvar b = tgr_pkg::LEVEL_W - 1; b >= 0; b--) begin : g_div
        tgr_div_stage #(
            .BIT (b)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (word[b + 1]),
            .i_den   (cfg.den),
            .o_word  (word[b])
        );
    end

    assign o_result_valid  = word[0].valid;
    assign o_red_level     = word[0].quo[0];
    assign o_green_level   = word[0].quo[1];
    assign o_blue_level    = word[0].quo[2];
    assign o_index_clamped = word[0].clamped;

`ifndef SYNTHESIS
    a_word_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(tgr_pkg::LATENCY) o_result_valid)
        else $error("accepted word produced no result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##(tgr_pkg::LATENCY) !o_result_valid)
        else $error("result without an accepted word");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg.den != '0)
        else $error("divisor is zero");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the tinted gamma ramp entry core.
// ----------------------------------------------------------------------------
// A directed table covers reset values, both ends of the ramp, size zero and
// one, oversized ramps, clamped indexes and tint extremes. Random phases then
// load new tint and size settings while the core is idle and send ramp indexes
// in bursts with random gaps. Every word from the core is compared with the
// table's levels or with a level predictor that tracks the same configuration.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RAMP_MAX     = 1024;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_ROWS       = 25;
    localparam int N_PHASES     = 9;
    localparam int PHASE_ITEMS  = 106;

    typedef struct packed {
        logic [tgr_pkg::LEVEL_W-1:0] red;
        logic [tgr_pkg::LEVEL_W-1:0] green;
        logic [tgr_pkg::LEVEL_W-1:0] blue;
        logic                        clamped;
    } t_ramp_entry;

    typedef struct packed {
        logic [tgr_pkg::DATA_W-1:0] tint_r;
        logic [tgr_pkg::DATA_W-1:0] tint_g;
        logic [tgr_pkg::DATA_W-1:0] tint_b;
        logic [tgr_pkg::DATA_W-1:0] size;
        logic [tgr_pkg::IDX_W-1:0]  idx;
        logic                       known;
        t_ramp_entry                levels;
    } t_ramp_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [tgr_pkg::IDX_W-1:0]     i_ramp_index = '0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [tgr_pkg::CIDX_W-1:0]    i_cfg_index = '0;
    logic [tgr_pkg::DATA_W-1:0]    i_cfg_data = '0;
    logic                          o_result_valid;
    logic [tgr_pkg::LEVEL_W-1:0]   o_red_level;
    logic [tgr_pkg::LEVEL_W-1:0]   o_green_level;
    logic [tgr_pkg::LEVEL_W-1:0]   o_blue_level;
    logic                          o_index_clamped;

    logic [tgr_pkg::TINT_W-1:0]    cur_tint [tgr_pkg::NCH];
    logic [tgr_pkg::SIZE_W-1:0]    cur_size;
    logic [tgr_pkg::DATA_W-1:0]    written [4];
    t_ramp_entry                   expected_levels [$];
    int                            mismatches = 0;
    int                            cycle_count = 0;

    t_ramp_row dir_rows [N_ROWS] = '{
        '{11'd255, 11'd255, 11'd255, 11'd256, 10'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd256, 10'd1, 1'b1,
          '{16'd257, 16'd257, 16'd257, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd256, 10'd255, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd256, 10'd1023, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b1}},
        '{11'd255, 11'd255, 11'd255, 11'd256, 10'd256, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b1}},
        '{11'd255, 11'd255, 11'd255, 11'd256, 10'd170, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd128, 11'd0, 11'h7ff, 11'd256, 10'd255, 1'b1,
          '{16'd32896, 16'd0, 16'd65535, 1'b0}},
        '{11'h100, 11'd1, 11'd200, 11'd256, 10'd255, 1'b1,
          '{16'd0, 16'd257, 16'd51400, 1'b0}},
        '{11'h100, 11'd1, 11'd200, 11'd256, 10'd100, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd1, 10'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd1, 10'd1023, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{11'd255, 11'd255, 11'd255, 11'd0, 10'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd0, 10'd7, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}},
        '{11'd255, 11'd255, 11'd255, 11'd2, 10'd0, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd2, 10'd1, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd2, 10'd2, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b1}},
        '{11'd37, 11'd99, 11'd255, 11'd1024, 10'd1023, 1'b1,
          '{16'd9509, 16'd25443, 16'd65535, 1'b0}},
        '{11'd37, 11'd99, 11'd255, 11'd1024, 10'd512, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd37, 11'd99, 11'd255, 11'd1024, 10'd1, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'd1025, 10'd1023, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'h7ff, 10'd1023, 1'b1,
          '{16'd65535, 16'd65535, 16'd65535, 1'b0}},
        '{11'd255, 11'd255, 11'd255, 11'h7ff, 10'h2aa, 1'b0, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd1, 11'd1, 11'd1, 11'd1024, 10'd1023, 1'b1,
          '{16'd257, 16'd257, 16'd257, 1'b0}},
        '{11'd1, 11'd1, 11'd1, 11'd1024, 10'd1, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b0}},
        '{11'd255, 11'd254, 11'd253, 11'd3, 10'd2, 1'b1,
          '{16'd65535, 16'd65278, 16'd65021, 1'b0}}
    };

    tinted_gamma_ramp_entry_core #(
        .MAX_RAMP_SIZE(RAMP_MAX)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_ramp_index   (i_ramp_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_red_level    (o_red_level),
        .o_green_level  (o_green_level),
        .o_blue_level   (o_blue_level),
        .o_index_clamped(o_index_clamped)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** tinted_gamma_ramp_entry_core: FAILED **");
            $finish;
        end
    end

    function automatic logic [tgr_pkg::LEVEL_W-1:0] ramp_level(
            logic [tgr_pkg::IDX_W-1:0]  pos,
            logic [tgr_pkg::TINT_W-1:0] tint,
            logic [tgr_pkg::LAST_W-1:0] last);
        logic [63:0] quo;
        if (last == '0) begin
            return '0;
        end
        quo = (64'(pos) * 64'd65535 * 64'(tint)) / (64'd255 * 64'(last));
        return quo[tgr_pkg::LEVEL_W-1:0];
    endfunction

    function automatic logic [tgr_pkg::LAST_W-1:0] cur_last();
        logic [tgr_pkg::SIZE_W-1:0] size;
        size = cur_size;
        if (size == '0) begin
            size = tgr_pkg::SIZE_W'(1);
        end
        if (size > tgr_pkg::SIZE_W'(RAMP_MAX)) begin
            size = tgr_pkg::SIZE_W'(RAMP_MAX);
        end
        return size - 1'b1;
    endfunction

    function automatic t_ramp_entry predict_levels(logic [tgr_pkg::IDX_W-1:0] idx);
        logic [tgr_pkg::LAST_W-1:0] last;
        logic [tgr_pkg::IDX_W-1:0]  pos;
        t_ramp_entry                e;
        last = cur_last();
        pos = idx;
        e.clamped = 1'b0;
        if (tgr_pkg::LAST_W'(idx) > last) begin
            pos = last[tgr_pkg::IDX_W-1:0];
            e.clamped = 1'b1;
        end
        e.red = ramp_level(pos, cur_tint[0], last);
        e.green = ramp_level(pos, cur_tint[1], last);
        e.blue = ramp_level(pos, cur_tint[2], last);
        return e;
    endfunction

    function automatic logic [tgr_pkg::IDX_W-1:0] pick_index();
        logic [tgr_pkg::LAST_W-1:0] last;
        last = cur_last();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return last[tgr_pkg::IDX_W-1:0];
            2: return '1;
            3, 4: return tgr_pkg::IDX_W'($urandom);
            default: return tgr_pkg::IDX_W'($urandom_range(0, last));
        endcase
    endfunction

    function automatic logic [tgr_pkg::DATA_W-1:0] pick_tint();
        case ($urandom_range(0, 5))
            0: return tgr_pkg::DATA_W'(0);
            1: return tgr_pkg::DATA_W'(255);
            default: return tgr_pkg::DATA_W'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [tgr_pkg::DATA_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return tgr_pkg::DATA_W'(0);
            1: return tgr_pkg::DATA_W'(1);
            2: return tgr_pkg::DATA_W'(2);
            3: return tgr_pkg::DATA_W'(RAMP_MAX);
            4: return tgr_pkg::DATA_W'($urandom_range(RAMP_MAX + 1, 2047));
            default: return tgr_pkg::DATA_W'($urandom_range(1, RAMP_MAX));
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_ramp_entry got;
        t_ramp_entry want;
        if (i_rst_n && o_result_valid) begin
            got = '{o_red_level, o_green_level, o_blue_level, o_index_clamped};
            if (expected_levels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: red %0d green %0d blue %0d clamped %0d",
                             got.red, got.green, got.blue, got.clamped);
                end
            end else begin
                want = expected_levels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.clamped !== want.clamped) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.red, want.green, want.blue, want.clamped,
                                 got.red, got.green, got.blue, got.clamped);
                    end
                end
            end
        end
    end

    task automatic cfg_write(tgr_pkg::t_cfg_reg addr, logic [tgr_pkg::DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= addr;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        written[addr] = data;
        case (addr)
            tgr_pkg::CFG_TINT_RED:   cur_tint[0] = data[tgr_pkg::TINT_W-1:0];
            tgr_pkg::CFG_TINT_GREEN: cur_tint[1] = data[tgr_pkg::TINT_W-1:0];
            tgr_pkg::CFG_TINT_BLUE:  cur_tint[2] = data[tgr_pkg::TINT_W-1:0];
            tgr_pkg::CFG_RAMP_SIZE:  cur_size = data;
            default: ;
        endcase
    endtask

    task automatic load_ramp(logic [tgr_pkg::DATA_W-1:0] tr, logic [tgr_pkg::DATA_W-1:0] tg,
                             logic [tgr_pkg::DATA_W-1:0] tb,
                             logic [tgr_pkg::DATA_W-1:0] size);
        cfg_write(tgr_pkg::CFG_TINT_RED, tr);
        cfg_write(tgr_pkg::CFG_TINT_GREEN, tg);
        cfg_write(tgr_pkg::CFG_TINT_BLUE, tb);
        cfg_write(tgr_pkg::CFG_RAMP_SIZE, size);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_index(logic [tgr_pkg::IDX_W-1:0] idx, logic known,
                              t_ramp_entry levels);
        start <= 1'b1;
        i_ramp_index <= idx;
        do @(posedge i_clk); while (busy);
        expected_levels.push_back(known ? levels : predict_levels(idx));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_levels.size() != 0) begin
            @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    initial begin
        int left;
        int burst;
        int gap;
        logic [tgr_pkg::DATA_W-1:0] tr;
        logic [tgr_pkg::DATA_W-1:0] tg;
        logic [tgr_pkg::DATA_W-1:0] tb;
        logic [tgr_pkg::DATA_W-1:0] size;

        cur_tint[0] = tgr_pkg::TINT_RESET;
        cur_tint[1] = tgr_pkg::TINT_RESET;
        cur_tint[2] = tgr_pkg::TINT_RESET;
        cur_size = tgr_pkg::SIZE_RESET;
        written[0] = tgr_pkg::DATA_W'(tgr_pkg::TINT_RESET);
        written[1] = tgr_pkg::DATA_W'(tgr_pkg::TINT_RESET);
        written[2] = tgr_pkg::DATA_W'(tgr_pkg::TINT_RESET);
        written[3] = tgr_pkg::SIZE_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].tint_r !== written[0] || dir_rows[r].tint_g !== written[1] ||
                dir_rows[r].tint_b !== written[2] || dir_rows[r].size !== written[3]) begin
                drain();
                load_ramp(dir_rows[r].tint_r, dir_rows[r].tint_g,
                          dir_rows[r].tint_b, dir_rows[r].size);
            end
            send_index(dir_rows[r].idx, dir_rows[r].known, dir_rows[r].levels);
        end
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 0) begin
                tr = 11'd255; tg = 11'd255; tb = 11'd255;
                size = tgr_pkg::DATA_W'(RAMP_MAX);
            end else if (p == 1) begin
                tr = 11'd0; tg = 11'd0; tb = 11'd0; size = 11'd2;
            end else begin
                tr = pick_tint(); tg = pick_tint(); tb = pick_tint(); size = pick_size();
            end
            load_ramp(tr, tg, tb, size);
            left = PHASE_ITEMS;
            while (left > 0) begin
                burst = $urandom_range(1, 32);
                for (int k = 0; k < burst && left > 0; k++) begin
                    send_index(pick_index(), 1'b0, '0);
                    left--;
                    if (left == PHASE_ITEMS / 2) begin
                        drain();
                    end
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            drain();
        end

        repeat (tgr_pkg::LATENCY + 4) @(posedge i_clk);
        if (mismatches == 0 && expected_levels.size() == 0) begin
            $display("** tinted_gamma_ramp_entry_core: PASSED **");
        end else begin
            $display("** tinted_gamma_ramp_entry_core: FAILED **");
        end
        $finish;
    end

endmodule
